// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the key list RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/mkl_pkg.sv
// ---------------------------------------------------------------------------
// mkl_pkg
// Types and fixed constants shared by the key list core and its cells.
// ---------------------------------------------------------------------------
`default_nettype none

package mkl_pkg;

   // Fixed field widths.
   localparam int KEY_W = 32;
   localparam int POS_W = 4;
   localparam int CNT_W = 5;
   localparam int CAP_W = 5;
   localparam int ACT_W = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

   // Requested operation.
   typedef enum logic [ACT_W-1:0] {
      ACT_ADD    = 3'd0,
      ACT_REMOVE = 3'd1,
      ACT_CLEAR  = 3'd2,
      ACT_READ   = 3'd3,
      ACT_APPEND = 3'd4
   } action_type;

   // Update applied to every cell in the execute cycle.
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_PUSH = 2'd1,
      CELL_PULL = 2'd2,
      CELL_LOAD = 2'd3
   } cell_op_type;

   // Control broadcast to the row of cells.
   typedef struct packed {
      logic        sample;
      cell_op_type op;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/mkl_cell.sv
// ---------------------------------------------------------------------------
// mkl_cell
// One list position: holds a key, compares it with the broadcast key and
// shifts towards either neighbour under the broadcast control.
// ---------------------------------------------------------------------------
`default_nettype none

module mkl_cell #(
   parameter int KEY_BITS = 32,
   parameter int INDEX    = 0
) (
   input  wire                          clock,
   input  mkl_pkg::cell_ctl_type        ctl_i,
   input  wire [mkl_pkg::CNT_W-1:0]     held_i,
   input  wire [KEY_BITS-1:0]           key_i,
   input  wire [KEY_BITS-1:0]           left_key_i,
   input  wire [KEY_BITS-1:0]           right_key_i,
   input  wire                          before_i,
   output logic [KEY_BITS-1:0]          key_o,
   output logic                         before_o
);
   import mkl_pkg::*;

   logic [KEY_BITS-1:0] entry_ff, entry_in;
   logic                hit_ff, hit_in;
   logic                occupied;
   logic                at_tail;

   assign occupied = INDEX < int'(held_i);
   assign at_tail  = INDEX == int'(held_i);

   // A hit only counts for a position that holds a live key.
   assign hit_in = occupied && (entry_ff == key_i);

   // A match lies at or ahead of this position.
   assign before_o = before_i | hit_ff;
   assign key_o    = entry_ff;

   // Next stored key for the broadcast operation.
   always_comb begin
      entry_in = entry_ff;
      case (ctl_i.op)
         CELL_PUSH: begin
            if (INDEX == 0) begin
               entry_in = key_i;
            end else if (!before_i) begin
               entry_in = left_key_i;
            end
         end
         CELL_PULL: begin
            if (before_o) begin
               entry_in = right_key_i;
            end
         end
         CELL_LOAD: begin
            if (at_tail) begin
               entry_in = key_i;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Key storage and the compare result of the current item.
   always_ff @(posedge clock) begin
      if (ctl_i.sample) begin
         hit_ff <= hit_in;
      end
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/mru_key_list_core.sv
// ---------------------------------------------------------------------------
// mru_key_list_core
// Most-recently-used key list built from a row of shifting cells.
// ---------------------------------------------------------------------------
// Each item passes through the idle and execute states: in the cycle it is
// accepted every cell compares its stored key with the item's key, and in the
// execute state the first-match chain running along the row steers a one-place
// shift (or a tail load) in every cell at once while the result is written to
// the output register. A new item is taken as soon as the execute state has
// passed, even while the previous result still waits; if a result is still
// unclaimed when the next one is finished, the block holds in its execute
// state until the output register is free. Positions at or beyond the count
// are never read, so the storage needs no clearing after reset.
`default_nettype none

`include "assert_macros.svh"

module mru_key_list_core #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 32
) (
   input  wire                        clock,
   input  wire                        reset,
   // Request items.
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // [31:0] key, [35:32] position, [39:36] zero
   input  wire [39:0]                 req_tdata,
   // [2:0] action
   input  wire [mkl_pkg::ACT_W-1:0]   req_tuser,
   // Result items.
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // [31:0] read_key, [32] read_valid, [33] matched, [38:34] entry_count,
   // [39] zero
   output logic [39:0]                rsp_tdata,
   // Capacity register write.
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [mkl_pkg::CAP_W-1:0]   csr_data
);
   import mkl_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   state_type            state_ff, state_in;
   action_type           act_ff, act_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     held_ff, held_in;
   logic [CAP_W-1:0]     capacity_ff, capacity_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [39:0]          rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 out_free;
   logic                 exec_done;
   logic                 matched;
   logic [CAP_W-1:0]     cap_eff;
   logic [CNT_W:0]       add_count;
   logic                 room;
   logic                 read_hit;
   logic [KEY_W-1:0]     read_key;
   logic [KEY_BITS-1:0]  bcast_key;
   cell_ctl_type         cell_ctl;

   logic [KEY_BITS-1:0]  cell_key   [DEPTH];
   logic [KEY_BITS-1:0]  left_key   [DEPTH];
   logic [KEY_BITS-1:0]  right_key  [DEPTH];
   logic                 cell_before [DEPTH+1];

   // Handshakes.
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign exec_done  = (state_ff == ST_EXEC) && out_free;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Capacity as it acts: zero counts as one, anything above the depth as the depth.
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (int'(capacity_ff) > DEPTH) begin
         cap_eff = CAP_W'(DEPTH);
      end else begin
         cap_eff = capacity_ff;
      end
   end

   assign matched = cell_before[DEPTH];
   assign room    = (held_ff < cap_eff) && (int'(held_ff) < DEPTH);

   // Count after an add: one more, less the removed copy, trimmed to the capacity.
   always_comb begin
      add_count = {1'b0, held_ff} - {{CNT_W{1'b0}}, matched} + (CNT_W+1)'(1);
      if (add_count > {1'b0, cap_eff}) begin
         add_count = add_count - (CNT_W+1)'(1);
      end
      if (int'(add_count) > DEPTH) begin
         add_count = (CNT_W+1)'(DEPTH);
      end
   end

   // Read port over the row of cells.
   always_comb begin
      read_hit = (int'(pos_ff) < DEPTH) && ({1'b0, pos_ff} < held_ff);
      read_key = '0;
      if (read_hit) begin
         read_key = KEY_W'(cell_key[IDX_W'(pos_ff)]);
      end
   end

   // Broadcast key and cell control.
   assign bcast_key = (state_ff == ST_IDLE) ? KEY_BITS'(req_tdata[KEY_W-1:0]) : key_ff;

   always_comb begin
      cell_ctl.sample = accept;
      cell_ctl.op     = CELL_HOLD;
      if (exec_done) begin
         case (act_ff)
            ACT_ADD:    cell_ctl.op = CELL_PUSH;
            ACT_REMOVE: cell_ctl.op = CELL_PULL;
            ACT_APPEND: cell_ctl.op = room ? CELL_LOAD : CELL_HOLD;
            default:    cell_ctl.op = CELL_HOLD;
         endcase
      end
   end

   // Row of cells, each linked to both neighbours and to the match chain.
   assign cell_before[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_key[i] = cell_key[i];
      end else begin : g_left
         assign left_key[i] = cell_key[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_key[i] = cell_key[i];
      end else begin : g_right
         assign right_key[i] = cell_key[i+1];
      end

      mkl_cell #(
         .KEY_BITS (KEY_BITS),
         .INDEX    (i)
      ) u_cell (
         .clock       (clock),
         .ctl_i       (cell_ctl),
         .held_i      (held_ff),
         .key_i       (bcast_key),
         .left_key_i  (left_key[i]),
         .right_key_i (right_key[i]),
         .before_i    (cell_before[i]),
         .key_o       (cell_key[i]),
         .before_o    (cell_before[i+1])
      );
   end

   // Sequencing, count, capacity and result register.
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      held_in      = held_ff;
      capacity_in  = capacity_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         capacity_in = csr_data;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in   = action_type'(req_tuser);
               key_in   = KEY_BITS'(req_tdata[KEY_W-1:0]);
               pos_in   = req_tdata[KEY_W +: POS_W];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_data_in = '0;
               case (act_ff)
                  ACT_ADD: begin
                     held_in        = add_count[CNT_W-1:0];
                     rsp_data_in[33] = matched;
                  end
                  ACT_REMOVE: begin
                     held_in        = held_ff - {{(CNT_W-1){1'b0}}, matched};
                     rsp_data_in[33] = matched;
                  end
                  ACT_CLEAR: begin
                     held_in = '0;
                  end
                  ACT_READ: begin
                     rsp_data_in[KEY_W-1:0] = read_key;
                     rsp_data_in[32]        = read_hit;
                  end
                  ACT_APPEND: begin
                     if (room) begin
                        held_in = held_ff + CNT_W'(1);
                     end
                  end
                  default: begin
                     held_in = held_ff;
                  end
               endcase
               rsp_data_in[38:34] = held_in;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Only one item is in work at a time.
   `ASSERT_NEXT(a_one_item, clock, reset, accept, !req_tready)
   // A remove that found its key shortens the list by exactly one.
   `ASSERT_NEXT(a_remove_count, clock, reset,
      exec_done && (act_ff == ACT_REMOVE) && matched, held_ff == $past(held_ff) - CNT_W'(1))
   // An add always leaves at least one key in the list.
   `ASSERT_NEXT(a_add_nonempty, clock, reset, exec_done && (act_ff == ACT_ADD), held_ff != '0)

endmodule

`default_nettype wire

// File: tb/mru_key_list_core_tb.sv
// ---------------------------------------------------------------------------
// mru_key_list_core_tb
// Self-checking bench for the most-recently-used key list core.
// ---------------------------------------------------------------------------
// Request items are offered on the request stream and every result is
// compared with a behavioural copy of the list held here. A short table of
// directed items comes first. It is followed by random phases, one per
// capacity setting, using keys drawn mostly from a small pool so that adds
// and removes often hit. Both streams pause at random, and in one phase the
// output is held back long enough for the core to stall its input. The last
// phase runs without pauses.
// ---------------------------------------------------------------------------

module mru_key_list_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import mkl_pkg::*;

   localparam int          LIST_DEPTH      = 16;
   localparam int          PHASES          = 10;
   localparam int          ITEMS_PER_PHASE = 170;
   localparam int          PRESSURE_PHASE  = 3;
   localparam int          LONG_HOLD       = 64;
   localparam int          DRAIN_CYCLES    = 4;
   localparam int          QUIET_LIMIT     = 2000;
   localparam int          POOL_SIZE       = 20;

   // Action codes the core does not define; they must leave the list alone.
   localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [KEY_W-1:0] read_key;
      logic             read_valid;
      logic             matched;
      logic [CNT_W-1:0] entry_count;
   } list_reply_type;

   typedef struct {
      logic [ACT_W-1:0] act;
      logic [KEY_W-1:0] key;
      logic [POS_W-1:0] pos;
      bit               pinned;
      list_reply_type   reply;
   } directed_row_type;

   // Clock, reset and core ports; every input of the core starts at a known value.
   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [39:0]         req_tdata  = '0;
   logic [ACT_W-1:0]    req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [CAP_W-1:0]    csr_data   = '0;

   // Behavioural copy of the list.
   logic [KEY_W-1:0]    list_keys [LIST_DEPTH];
   int unsigned         held_model     = 0;
   logic [CAP_W-1:0]    capacity_model = CAP_RESET;

   // Expected results, oldest first, and a typed-in expectation for the
   // item currently on offer.
   list_reply_type      replies_due [$];
   bit                  pin_active = 1'b0;
   list_reply_type      pin_reply  = '0;

   directed_row_type    directed_rows [$];
   logic [KEY_W-1:0]    key_pool [POOL_SIZE];

   int unsigned         req_idle_pct  = 0;
   int unsigned         rsp_idle_pct  = 0;
   int unsigned         hold_requests = 0;
   int unsigned         quiet_cycles  = 0;
   int unsigned         failures      = 0;
   int unsigned         items_taken   = 0;
   int unsigned         results_seen  = 0;
   int unsigned         reads_hit     = 0;
   int unsigned         keys_matched  = 0;

   mru_key_list_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Position of the most recent copy of a key, or the count when absent.
   function automatic int unsigned locate_key(logic [KEY_W-1:0] k);
      int unsigned i;
      for (i = 0; i < held_model; i++)
         if (list_keys[i] == k) return i;
      return held_model;
   endfunction

   // Take out one entry and close the gap behind it.
   function automatic void drop_entry(int unsigned p);
      int unsigned i;
      for (i = p; i + 1 < held_model; i++)
         list_keys[i] = list_keys[i + 1];
      held_model--;
   endfunction

   // Apply one request item to the copy of the list and return its result.
   function automatic list_reply_type apply_list_action(logic [ACT_W-1:0] act,
                                                        logic [KEY_W-1:0] k,
                                                        logic [POS_W-1:0] pos);
      list_reply_type r;
      int unsigned lim;
      int unsigned hit;
      int unsigned n;
      int          i;
      r   = '0;
      lim = (capacity_model == 0) ? 1 :
            (capacity_model > LIST_DEPTH) ? LIST_DEPTH : capacity_model;
      case (act)
         ACT_ADD: begin
            hit = locate_key(k);
            if (hit < held_model) begin
               r.matched = 1'b1;
               drop_entry(hit);
            end
            // Shift the whole row down one place; the bottom entry may fall off.
            n = held_model + 1;
            for (i = ((n < LIST_DEPTH) ? n : LIST_DEPTH) - 1; i > 0; i--)
               list_keys[i] = list_keys[i - 1];
            list_keys[0] = k;
            if (n > lim) n--;
            if (n > LIST_DEPTH) n = LIST_DEPTH;
            held_model = n;
         end
         ACT_REMOVE: begin
            hit = locate_key(k);
            if (hit < held_model) begin
               r.matched = 1'b1;
               drop_entry(hit);
            end
         end
         ACT_CLEAR: held_model = 0;
         ACT_READ: begin
            if (pos < held_model) begin
               r.read_valid = 1'b1;
               r.read_key   = list_keys[pos];
            end
         end
         ACT_APPEND: begin
            if (held_model < lim) begin
               list_keys[held_model] = k;
               held_model++;
            end
         end
         default: ;
      endcase
      r.entry_count = held_model[CNT_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   function automatic void push_row(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                                    logic [POS_W-1:0] pos, bit pinned,
                                    logic [KEY_W-1:0] rkey, logic rvalid,
                                    logic match, logic [CNT_W-1:0] count);
      directed_row_type row;
      row.act               = act;
      row.key               = k;
      row.pos               = pos;
      row.pinned            = pinned;
      row.reply.read_key    = rkey;
      row.reply.read_valid  = rvalid;
      row.reply.matched     = match;
      row.reply.entry_count = count;
      directed_rows.push_back(row);
   endfunction

   // Mostly pool keys, so that adds and removes find their key often.
   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 85) return r[0] ? '1 : '0;
      return $urandom();
   endfunction

   // Monitor: check results, track capacity writes and predict each item.
   always @(posedge clock) begin
      list_reply_type got;
      list_reply_type want;
      if (!reset) begin
         got.read_key    = rsp_tdata[31:0];
         got.read_valid  = rsp_tdata[32];
         got.matched     = rsp_tdata[33];
         got.entry_count = rsp_tdata[38:34];
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (got.read_valid) reads_hit++;
            if (got.matched) keys_matched++;
            if (replies_due.size() == 0) begin
               failures++;
               $display("%0t ns: result %h arrived with no item outstanding",
                        $time, rsp_tdata);
            end else begin
               want = replies_due.pop_front();
               check_field("read_key", want.read_key, got.read_key);
               check_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
               check_field("matched", 32'(want.matched), 32'(got.matched));
               check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
            end
         end
         if (csr_valid && csr_ready) capacity_model = csr_data;
         if (req_tvalid && req_tready) begin
            items_taken++;
            want = apply_list_action(req_tuser, req_tdata[31:0], req_tdata[35:32]);
            if (pin_active) want = pin_reply;
            replies_due.push_back(want);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   // Ends the run if nothing moves for too long.
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // Result side: random pauses, plus a long hold on request.
   initial begin : response_sink
      int unsigned served;
      served = 0;
      forever begin
         @(negedge clock);
         if (served != hold_requests) begin
            served = hold_requests;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Offer one item, starting and ending at a falling edge. The valid stays
   // high afterwards so that back-to-back items need no second assignment.
   task automatic offer_item(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                             logic [POS_W-1:0] pos, bit pinned, list_reply_type pin);
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      pin_active = pinned;
      pin_reply  = pin;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, pos, k};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stop offering and let every outstanding result come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CAP_W-1:0] phase_caps [PHASES];
      int unsigned      phase;
      int unsigned      n;
      int unsigned      r;
      int unsigned      burst;
      int unsigned      j;
      logic [POS_W-1:0] pos;

      phase_caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd17, 5'd16, 5'd2, 5'd10, 5'd0};
      phase_caps[7] = CAP_W'($urandom_range(0, 31));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items at the reset capacity of ten.
      push_row(ACT_READ,    32'h0,        4'h0, 1, 32'h0,        0, 0, 5'd0);
      push_row(ACT_REMOVE,  32'h0,        4'h0, 1, 32'h0,        0, 0, 5'd0);
      push_row(ACT_CLEAR,   32'hFFFFFFFF, 4'hF, 1, 32'h0,        0, 0, 5'd0);
      push_row(ACT_APPEND,  32'hFFFFFFFF, 4'hF, 1, 32'h0,        0, 0, 5'd1);
      push_row(ACT_ADD,     32'h0,        4'h0, 1, 32'h0,        0, 0, 5'd2);
      push_row(ACT_ADD,     32'hFFFFFFFF, 4'h0, 1, 32'h0,        0, 1, 5'd2);
      push_row(ACT_READ,    32'h0,        4'h0, 1, 32'hFFFFFFFF, 1, 0, 5'd2);
      push_row(ACT_READ,    32'hFFFFFFFF, 4'h1, 1, 32'h0,        1, 0, 5'd2);
      push_row(ACT_READ,    32'h0,        4'hF, 1, 32'h0,        0, 0, 5'd2);
      push_row(ACT_SPARE_5, 32'hFFFFFFFF, 4'hF, 1, 32'h0,        0, 0, 5'd2);
      push_row(ACT_SPARE_6, 32'h0,        4'h0, 1, 32'h0,        0, 0, 5'd2);
      push_row(ACT_SPARE_7, 32'hFFFFFFFF, 4'h1, 1, 32'h0,        0, 0, 5'd2);
      // Duplicates stored by append; add and remove touch the newest copy.
      push_row(ACT_APPEND,  32'hA5A5A5A5, 4'h0, 0, '0, 0, 0, '0);
      push_row(ACT_APPEND,  32'hA5A5A5A5, 4'h0, 0, '0, 0, 0, '0);
      push_row(ACT_ADD,     32'h5A5A5A5A, 4'h0, 0, '0, 0, 0, '0);
      push_row(ACT_REMOVE,  32'hA5A5A5A5, 4'h0, 0, '0, 0, 0, '0);
      push_row(ACT_READ,    32'h0,        4'h2, 0, '0, 0, 0, '0);
      push_row(ACT_READ,    32'h0,        4'h3, 0, '0, 0, 0, '0);
      push_row(ACT_REMOVE,  32'h12345678, 4'h0, 0, '0, 0, 0, '0);
      push_row(ACT_ADD,     32'hA5A5A5A5, 4'h0, 0, '0, 0, 0, '0);
      push_row(ACT_READ,    32'h0,        4'h0, 0, '0, 0, 0, '0);
      push_row(ACT_CLEAR,   32'h0,        4'h0, 1, 32'h0,        0, 0, 5'd0);
      push_row(ACT_APPEND,  32'h80000001, 4'h0, 1, 32'h0,        0, 0, 5'd1);
      push_row(ACT_READ,    32'h0,        4'h0, 1, 32'h80000001, 1, 0, 5'd1);
      push_row(ACT_REMOVE,  32'h80000001, 4'h0, 1, 32'h0,        0, 1, 5'd0);

      foreach (directed_rows[i])
         offer_item(directed_rows[i].act, directed_rows[i].key, directed_rows[i].pos,
                    directed_rows[i].pinned, directed_rows[i].reply);

      // Random phases, one capacity setting each.
      for (phase = 0; phase < PHASES; phase++) begin
         write_capacity(phase_caps[phase]);
         for (j = 0; j < POOL_SIZE; j++) key_pool[j] = $urandom();
         if (phase == PHASES - 1) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = (phase % 3 == 0) ? 0 : $urandom_range(5, 30);
            rsp_idle_pct = (phase % 3 == 2) ? 0 : $urandom_range(5, 40);
         end
         if (phase == PRESSURE_PHASE) begin
            req_idle_pct = 0;
            hold_requests++;
         end
         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            r   = $urandom_range(0, 99);
            pos = POS_W'($urandom_range(0, 15));
            if (r < 4) begin
               // Reload a saved list: a clear, then a run of appends.
               burst = $urandom_range(1, LIST_DEPTH + 1);
               offer_item(ACT_CLEAR, $urandom(), pos, 0, '0);
               repeat (burst)
                  offer_item(ACT_APPEND, pick_key(), POS_W'($urandom_range(0, 15)), 0, '0);
               n += burst + 1;
            end else begin
               if (r < 7)
                  offer_item(ACT_CLEAR, $urandom(), pos, 0, '0);
               else if (r < 10)
                  offer_item(ACT_W'($urandom_range(ACT_SPARE_5, ACT_SPARE_7)),
                             $urandom(), pos, 0, '0);
               else if (r < 45)
                  offer_item(ACT_ADD, pick_key(), pos, 0, '0);
               else if (r < 57)
                  offer_item(ACT_REMOVE, pick_key(), pos, 0, '0);
               else if (r < 70)
                  offer_item(ACT_APPEND, pick_key(), pos, 0, '0);
               else begin
                  // Reads mostly land inside the list, sometimes anywhere.
                  if ($urandom_range(0, 9) < 7)
                     pos = POS_W'($urandom_range(0, (held_model < 15) ? held_model : 15));
                  offer_item(ACT_READ, $urandom(), pos, 0, '0);
               end
               n++;
            end
         end
      end

      wait_drained();
      $display("Ran %0d items over %0d capacity settings; %0d results checked.",
               items_taken, PHASES + 1, results_seen);
      $display("%0d reads hit an entry, %0d adds or removes found their key.",
               reads_hit, keys_matched);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
